/* src/lbp_pkg.sv */
// Package for the streaming 3x3 local binary pattern core.
// Holds the channel payload types, register decode constants and the code function.
// Depends on nothing; used by lbp_line_mem and lbp_3x3_stream_core.
package lbp_pkg;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] lbp_code;
		logic       row_end;
		logic       frame_end;
	} lbp_out_t;

	// One line-store entry: the pixel two rows up and the pixel one row up.
	typedef struct packed {
		logic [7:0] older;
		logic [7:0] newer;
	} line_pair_t;

	// Register select bit of the configuration port (byte address bit 2).
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [10:0] WIDTH_RESET  = 11'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam logic [12:0] MIN_DIM      = 13'd3;
	localparam logic [12:0] MAX_HEIGHT   = 13'd4096;

	// Bit positions of the neighbors in the code, clockwise from upper-left.
	localparam int BIT_UL = 7;
	localparam int BIT_U  = 6;
	localparam int BIT_UR = 5;
	localparam int BIT_R  = 4;
	localparam int BIT_LR = 3;
	localparam int BIT_D  = 2;
	localparam int BIT_LL = 1;
	localparam int BIT_L  = 0;

	// Each bit is set when its neighbor is strictly brighter than the center.
	function automatic logic [7:0] lbp_code_f(
		input logic [7:0] ctr,
		input logic [7:0] ul, input logic [7:0] u,  input logic [7:0] ur,
		input logic [7:0] r,  input logic [7:0] lr, input logic [7:0] d,
		input logic [7:0] ll, input logic [7:0] l
	);
		logic [7:0] code;
		code         = '0;
		code[BIT_UL] = (ul > ctr);
		code[BIT_U]  = (u  > ctr);
		code[BIT_UR] = (ur > ctr);
		code[BIT_R]  = (r  > ctr);
		code[BIT_LR] = (lr > ctr);
		code[BIT_D]  = (d  > ctr);
		code[BIT_LL] = (ll > ctr);
		code[BIT_L]  = (l  > ctr);
		return code;
	endfunction

endpackage

/* src/lbp_line_mem.sv */
// Line store for the 3x3 window: one memory holding both previous rows per column.
// Registered read with a forward path for a write to the same column in the same cycle.
// Depends on lbp_pkg (line_pair_t).
module lbp_line_mem #(
	parameter int DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  lbp_pkg::line_pair_t       wr_data,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output lbp_pkg::line_pair_t       rd_data
);
	import lbp_pkg::*;

	line_pair_t mem [DEPTH];
	line_pair_t mem_rd_q;
	line_pair_t fwd_data_q;
	logic       fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			fwd_data_q <= wr_data;
			fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : mem_rd_q;

endmodule

/* src/lbp_3x3_stream_core.sv */
// Top level of the streaming 3x3 local binary pattern core.
// Depends on lbp_pkg and lbp_line_mem.
//
// Usage: grayscale pixels enter in raster order on the pix channel, one per
// transfer; frame_start on a pixel puts it at row 0, column 0. The code channel
// carries one 8-bit pattern for every interior pixel, so a frame of H x W
// pixels gives (H-2) x (W-2) codes, with row_end on the last code of each
// output row and frame_end on the last code of the frame. The code for center
// (r-1, c-1) is formed in stage 1 once pixel (r, c) is accepted and is shown on
// the code channel from the output register. The core takes one pixel per clock
// unless the code channel stalls, limited by the single read and single write
// of the line store per cycle. frame_width and frame_height are set over the
// APB port (byte addresses 0 and 4); the user sets them only while the core is
// idle, which the core does not enforce. Out-of-range values are clamped to
// 3..MAX_WIDTH and 3..4096. Reset clears the position counters, the window and
// the pipeline valid flags; the line store is not cleared and needs no sweep.
// When the receiver stalls, the output register holds its code and the core
// stops taking pixels only once the stage in front of it is also full.
module lbp_3x3_stream_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	// pixel input channel
	input  logic             pix_valid,
	output logic             pix_stall,
	input  lbp_pkg::pix_in_t pix_data,
	// code output channel
	output logic             code_valid,
	input  logic             code_stall,
	output lbp_pkg::lbp_out_t code_data,
	// configuration port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lbp_pkg::*;

	// Column index width and the width used to compare against frame_width.
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
	localparam logic [CW-1:0] MAX_W = CW'(MAX_WIDTH);
	localparam logic [CW-1:0] MIN_W = CW'(3);

	// Configuration registers.
	logic [10:0] width_q;
	logic [12:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Effective frame size after clamping.
	logic [CW-1:0] width_ext;
	logic [CW-1:0] eff_w;
	logic [12:0]   eff_h;

	assign width_ext = CW'(width_q);

	always_comb begin
		if (width_ext < MIN_W) begin
			eff_w = MIN_W;
		end else if (width_ext > MAX_W) begin
			eff_w = MAX_W;
		end else begin
			eff_w = width_ext;
		end
		if (height_q < MIN_DIM) begin
			eff_h = MIN_DIM;
		end else if (height_q > MAX_HEIGHT) begin
			eff_h = MAX_HEIGHT;
		end else begin
			eff_h = height_q;
		end
	end

	// Handshake and pipeline control. Stage 1 holds the accepted pixel while the
	// line store read completes; the result register is stage 2.
	logic pix_accept;
	logic adv_s1;
	logic valid_s1;
	logic res_valid_s2;

	assign adv_s1     = valid_s1 && (!res_valid_s2 || !code_stall);
	assign pix_stall  = valid_s1 && !adv_s1;
	assign pix_accept = pix_valid && !pix_stall;

	// Position of the incoming pixel. A counter past a shrunken bound is held at
	// the last position so that it still ends the row or frame and wraps.
	logic [AW-1:0] col_q;
	logic [11:0]   row_q;
	logic [CW-1:0] col_raw;
	logic [12:0]   row_raw;
	logic [CW-1:0] col_cur;
	logic [12:0]   row_cur;
	logic [AW-1:0] col_idx;
	logic          last_col;
	logic          last_row;
	logic          emit;

	always_comb begin
		col_raw = pix_data.frame_start ? '0 : CW'(col_q);
		row_raw = pix_data.frame_start ? '0 : 13'(row_q);
		col_cur = (col_raw >= eff_w) ? (eff_w - CW'(1)) : col_raw;
		row_cur = (row_raw >= eff_h) ? (eff_h - 13'd1) : row_raw;
		col_idx = col_cur[AW-1:0];
		last_col = (col_cur == (eff_w - CW'(1)));
		last_row = (row_cur == (eff_h - 13'd1));
		emit     = (row_cur >= 13'd2) && (col_cur >= CW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 12'd0 : row_cur[11:0] + 12'd1;
			end else begin
				col_q <= col_idx + AW'(1);
				row_q <= row_cur[11:0];
			end
		end
	end

	// Stage 1 registers.
	logic [7:0]    pix_s1;
	logic [AW-1:0] col_s1;
	logic          emit_s1;
	logic          row_end_s1;
	logic          frame_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			pix_s1       <= pix_data.pixel;
			col_s1       <= col_idx;
			emit_s1      <= emit;
			row_end_s1   <= last_col;
			frame_end_s1 <= last_col && last_row;
		end
	end

	// Line store: read at the incoming column, written back when stage 1 leaves.
	// The older row takes the value that was the newer row; the newer row takes
	// the current pixel.
	line_pair_t rd_pair;
	line_pair_t wr_pair;

	assign wr_pair.older = rd_pair.newer;
	assign wr_pair.newer = pix_s1;

	lbp_line_mem #(
		.DEPTH(MAX_WIDTH)
	) u_line_mem (
		.clk    (clk),
		.wr_en  (adv_s1),
		.wr_addr(col_s1),
		.wr_data(wr_pair),
		.rd_en  (pix_accept),
		.rd_addr(col_idx),
		.rd_data(rd_pair)
	);

	// Sliding window: the two previous columns, each top, middle, bottom.
	logic [7:0] win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= rd_pair.older;
			win_q[4] <= rd_pair.newer;
			win_q[5] <= pix_s1;
		end
	end

	// Pattern for the center, which is the middle of the previous column.
	logic [7:0] code_s1;

	assign code_s1 = lbp_code_f(win_q[4],
		win_q[0], win_q[3], rd_pair.older,
		rd_pair.newer, pix_s1, win_q[5],
		win_q[2], win_q[1]);

	// Stage 2: the output register.
	lbp_out_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			res_valid_s2 <= emit_s1;
		end else if (!code_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			res_s2.lbp_code  <= code_s1;
			res_s2.row_end   <= row_end_s1;
			res_s2.frame_end <= frame_end_s1;
		end
	end

	assign code_valid = res_valid_s2;
	assign code_data  = res_s2;

endmodule

/* bench/lbp_scoreboard.sv */
`timescale 1ns / 100ps
// Scoreboard for the streaming 3x3 local binary pattern core.
// Holds a predictor of codes and the queue of codes still owed by the core.
// Depends on lbp_pkg for the channel payload types and register selects.
package lbp_check_pkg;
	import lbp_pkg::*;

	localparam int LINE_DEPTH = 1024;

	class lbp_scoreboard;
		logic [10:0] width_reg;
		logic [12:0] height_reg;
		logic [7:0]  older_row [LINE_DEPTH];
		logic [7:0]  newer_row [LINE_DEPTH];
		// Columns c-2 (top, mid, bottom) then c-1 (top, mid, bottom).
		logic [7:0]  win [6];
		int          col_pos;
		int          row_pos;
		lbp_out_t    pending_codes [$];
		int          errors;

		function new();
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (older_row[i]) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			errors  = 0;
		endfunction

		function int eff_width();
			if (width_reg < MIN_DIM) return MIN_DIM;
			if (width_reg > LINE_DEPTH) return LINE_DEPTH;
			return width_reg;
		endfunction

		function int eff_height();
			if (height_reg < MIN_DIM) return MIN_DIM;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return height_reg;
		endfunction

		function void set_register(logic sel, logic [31:0] value);
			if (sel == REG_WIDTH) width_reg = value[10:0];
			else height_reg = value[12:0];
		endfunction

		function void note_pixel(pix_in_t p);
			int         w;
			int         h;
			int         c;
			int         r;
			bit         last_c;
			bit         last_r;
			logic [7:0] top;
			logic [7:0] mid;
			logic [7:0] ctr;
			lbp_out_t   res;
			w = eff_width();
			h = eff_height();
			if (p.frame_start) begin
				col_pos = 0;
				row_pos = 0;
			end
			// A counter left past a shrunken bound sits on the last position.
			c = (col_pos >= w) ? w - 1 : col_pos;
			r = (row_pos >= h) ? h - 1 : row_pos;
			last_c = (c == w - 1);
			last_r = (r == h - 1);
			top = older_row[c];
			mid = newer_row[c];
			if (r >= 2 && c >= 2) begin
				ctr = win[4];
				// Clockwise from upper-left down to the left neighbor.
				res.lbp_code = {win[0] > ctr, win[3] > ctr, top > ctr, mid > ctr,
					p.pixel > ctr, win[5] > ctr, win[2] > ctr, win[1] > ctr};
				res.row_end   = last_c;
				res.frame_end = last_c && last_r;
				pending_codes.push_back(res);
			end
			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = top;
			win[4] = mid;
			win[5] = p.pixel;
			older_row[c] = mid;
			newer_row[c] = p.pixel;
			if (last_c) begin
				col_pos = 0;
				row_pos = last_r ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
				row_pos = r;
			end
		endfunction

		task report(string msg);
			$display("%0t: code mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_code(lbp_out_t got);
			lbp_out_t want;
			if (pending_codes.size() == 0) begin
				report($sformatf("code %02h arrived with none owed", got.lbp_code));
				return;
			end
			want = pending_codes.pop_front();
			if (got.lbp_code !== want.lbp_code)
				report($sformatf("lbp_code %02h, want %02h", got.lbp_code, want.lbp_code));
			if (got.row_end !== want.row_end)
				report($sformatf("row_end %b, want %b", got.row_end, want.row_end));
			if (got.frame_end !== want.frame_end)
				report($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
		endtask
	endclass

endpackage

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Top of the bench for lbp_3x3_stream_core: clock, reset, pixel and APB drivers.
// Depends on lbp_pkg, lbp_check_pkg (scoreboard) and the core itself.
module tb_top;
	import lbp_pkg::*;
	import lbp_check_pkg::*;

	// Longest stretch without any transfer before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	// Random pixels per idling phase; four phases make up the random part.
	localparam int PHASE_ITEMS = 164;

	typedef enum {PAT_UNIFORM, PAT_NEAR, PAT_EXTREME, PAT_FLAT} pix_pattern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pix_valid = 1'b0;
	logic        pix_stall;
	pix_in_t     pix_data = '0;
	logic        code_valid;
	logic        code_stall = 1'b0;
	lbp_out_t    code_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int random_items = 0;
	// Set when the width grew mid-frame: the next frame must open with
	// frame_start so that no line-store entry is read before it is written.
	bit need_fresh = 1'b0;

	lbp_scoreboard sb = new();

	lbp_3x3_stream_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_data   (pix_data),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_data  (code_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #1 clk = ~clk;

	// The receiver decides afresh on every cycle whether to stall the code
	// channel, so stalls land on every phase of the core's pipeline.
	always @(posedge clk) begin
		code_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// Both monitors sample at the clock edge, before any nonblocking update of
	// that step, so they see exactly the values that decided each transfer.
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall) sb.note_pixel(pix_data);
	end

	always @(posedge clk) begin
		if (arst_n && code_valid && !code_stall) sb.check_code(code_data);
	end

	// One pixel transfer. The sender may first sit idle for a random number of
	// cycles; the payload is then held until the core stops stalling.
	task automatic send_pixel(input pix_in_t item);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data  <= item;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready. psel drops before return,
	// so back-to-back writes never assign psel twice in one step.
	task automatic write_register(input logic sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_register(sel, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Let the core drain: every owed code has to come out, and since border
	// pixels produce no code, a final wait covers pixels still in the pipeline.
	// The first edge lets the monitor note the last pixel transfer.
	task automatic settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_codes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_pixel(pix_pattern_t pat, logic [7:0] base);
		case (pat)
			PAT_NEAR: return base ^ 8'($urandom_range(3));
			PAT_EXTREME: return $urandom_range(1) ? 8'hFF - 8'($urandom_range(1))
				: 8'($urandom_range(1));
			PAT_FLAT: return ($urandom_range(3) != 0) ? base : 8'($urandom_range(255));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Streams the rest of the current frame, or a whole new one when fresh is
	// set. cap limits the count; may_cut sometimes breaks the frame off early.
	// A rare stray frame_start restarts the frame in the middle.
	task automatic run_frame(input bit fresh, input bit may_cut, input int cap);
		int           w;
		int           h;
		int           c;
		int           r;
		int           n;
		pix_pattern_t pat;
		logic [7:0]   base;
		pix_in_t      item;
		w = sb.eff_width();
		h = sb.eff_height();
		c = (sb.col_pos >= w) ? w - 1 : sb.col_pos;
		r = (sb.row_pos >= h) ? h - 1 : sb.row_pos;
		n = fresh ? w * h : (h - r) * w - c;
		if (cap > 0 && cap < n) n = cap;
		if (may_cut && $urandom_range(99) < 25) n = $urandom_range(n, 1);
		pat  = pix_pattern_t'($urandom_range(3));
		base = 8'($urandom_range(255));
		for (int i = 0; i < n; i++) begin
			item.frame_start = (fresh && i == 0) || ($urandom_range(299) == 0);
			item.pixel       = pick_pixel(pat, base);
			send_pixel(item);
		end
		random_items += n;
	endtask

	// New small frame geometry between frames or in the middle of one. Raw
	// values below three exercise the clamp; upper data bits carry garbage.
	task automatic reconfigure();
		int old_w;
		int pick;
		settle();
		old_w = sb.eff_width();
		pick  = $urandom_range(2);
		if (pick != 1)
			write_register(REG_WIDTH, ($urandom() & 32'hFFFF_F800) | 32'($urandom_range(12)));
		if (pick != 0)
			write_register(REG_HEIGHT, ($urandom() & 32'hFFFF_E000) | 32'($urandom_range(7)));
		if (sb.eff_width() > old_w && (sb.col_pos != 0 || sb.row_pos != 0))
			need_fresh = 1'b1;
	endtask

	// Watchdog: any transfer on either channel or the APB port, or reset,
	// counts as progress.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (pix_valid && !pix_stall) || (code_valid && !code_stall)
				|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : main_flow
		logic [7:0] directed_px [27];
		pix_in_t    item;
		bit         fresh;
		// Three 3x3 frames: a dark center under a bright ring, the reverse
		// (entered by frame wrap, without frame_start), and a mixed ring with
		// ties to the center, which must leave their bits clear.
		directed_px = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
			8'd101, 8'd100, 8'd99, 8'd200, 8'd100, 8'd7, 8'd100, 8'd101, 8'd100};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the smallest legal frame.
		write_register(REG_WIDTH, 32'd3);
		write_register(REG_HEIGHT, 32'd3);
		for (int i = 0; i < 27; i++) begin
			item.pixel       = directed_px[i];
			item.frame_start = (i == 0 || i == 18);
			send_pixel(item);
		end

		// Widest frame: 2047 clamps to the full line-store depth. The first
		// row and a few pixels of the second are sent, then the width shrinks
		// under the column counter; codes come out of the third row only if
		// the first row wrapped at the clamped width.
		settle();
		write_register(REG_WIDTH, 32'd2047);
		write_register(REG_HEIGHT, 32'd3);
		run_frame(1'b1, 1'b0, 1030);
		settle();
		write_register(REG_WIDTH, 32'd4);
		run_frame(1'b0, 1'b0, 0);

		// Tallest frame (8191 clamps to 4096), then the height shrinks under
		// the row counter, so the next row becomes the last one of the frame.
		settle();
		write_register(REG_WIDTH, 32'd0);
		write_register(REG_HEIGHT, 32'd8191);
		run_frame(1'b1, 1'b0, 90);
		settle();
		write_register(REG_HEIGHT, 32'd5);
		run_frame(1'b0, 1'b0, 0);

		// Width shrinks under the column counter mid-row: that pixel ends the row.
		settle();
		write_register(REG_WIDTH, 32'd12);
		run_frame(1'b1, 1'b0, 30);
		settle();
		write_register(REG_WIDTH, 32'd4);
		run_frame(1'b0, 1'b0, 0);

		// Random part in four idling phases: none, sender idle, receiver
		// stalling, and both together.
		random_items = 0;
		for (int phase = 0; phase < 4; phase++) begin
			src_idle_pct   = (phase == 1) ? 45 : (phase == 3) ? 27 : 0;
			sink_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 27 : 0;
			while (random_items < PHASE_ITEMS * (phase + 1)) begin
				// Without a register change, frames run back to back.
				if ($urandom_range(99) < 60) reconfigure();
				fresh = need_fresh || ($urandom_range(99) < 80);
				need_fresh = 1'b0;
				run_frame(fresh, 1'b1, 0);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_codes.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
